@@ design/cpsat_pkg.sv @@
// Shared types and constants for the convex polygon contact block.
// Holds the datapath command codes and the controller/datapath structs.
// No dependencies.
`default_nettype none
package cpsat_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned DIFF_W  = 25;
  localparam int unsigned PROD_W  = 50;
  localparam int unsigned PROJ_W  = 52;
  localparam int unsigned LEN_W   = 64;
  localparam int unsigned REM_W   = 48;
  localparam int unsigned QUO_W   = 15;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned VERT_W  = 2 * COORD_W;

  localparam logic [1:0] OP_ADD_A = 2'd0;
  localparam logic [1:0] OP_ADD_B = 2'd1;
  localparam logic [1:0] OP_TEST  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD_A,
    DP_LOAD_B,
    DP_CLEAR,
    DP_START,
    DP_READ_P,
    DP_LATCH_P1,
    DP_DIFF,
    DP_SQX,
    DP_SQY,
    DP_LEN,
    DP_NORM,
    DP_SQRT,
    DP_DIVX_INIT,
    DP_DIV,
    DP_DIVY_INIT,
    DP_DIV_END,
    DP_PD1,
    DP_PD2,
    DP_PD3,
    DP_READ_Q,
    DP_LATCH_Q,
    DP_QM1,
    DP_QM2,
    DP_QM3,
    DP_GAP,
    DP_DIR1,
    DP_DIR2,
    DP_DIR3,
    DP_SEP,
    DP_RESULT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   pass_b;
    logic   first;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic norm_done;
    logic gap_nonneg;
    logic res_busy;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ design/cpsat_in_if.sv @@
// Input channel of the contact block: valid/ready plus one item.
// Depends on cpsat_pkg.
`default_nettype none
interface cpsat_in_if
  import cpsat_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  dir_x;
  logic signed [COORD_W-1:0]  dir_y;

  modport source (output valid, operation, coord_x, coord_y, dir_x, dir_y, input ready);
  modport sink (input valid, operation, coord_x, coord_y, dir_x, dir_y, output ready);
endinterface
`default_nettype wire

@@ design/cpsat_out_if.sv @@
// Output channel of the contact block: valid/ready plus one result.
// Depends on cpsat_pkg.
`default_nettype none
interface cpsat_out_if
  import cpsat_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      overlapping;
  logic                      contact_found;
  logic signed [DIST_W-1:0]  contact_distance;
  logic signed [NORM_W-1:0]  normal_x;
  logic signed [NORM_W-1:0]  normal_y;

  modport source (output valid, overlapping, contact_found, contact_distance, normal_x,
                  normal_y, input ready);
  modport sink (input valid, overlapping, contact_found, contact_distance, normal_x,
                normal_y, output ready);
endinterface
`default_nettype wire

@@ design/convex_polygon_sat_contact.sv @@
// Top level of the 2D convex polygon separating-axis contact block.
// Depends on cpsat_pkg, cpsat_in_if, cpsat_out_if, cpsat_ctrl, cpsat_dp.
//
// Vertex loads and clears are accepted back to back. A test is worked
// through one step a cycle by a sequencer over a shared multiplier, a
// bit-serial square root and a restoring divider; it only holds at its end
// while the previous result has not been taken. Per edge of either polygon
// it reads the edge, squares its length, runs a normalizing shift loop on
// the squared length (shorter for longer edges), then takes 32 square-root
// steps, two 15-step divisions and a read, a latch and a multiply-accumulate
// per vertex of the other polygon; it stops early at the first separating
// edge. The block takes no new item while a test runs; its result sits in
// an output register, and a load may be accepted while it waits there.
`default_nettype none
module convex_polygon_sat_contact
  import cpsat_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  cpsat_in_if.sink      in_i,
  cpsat_out_if.source   out_o
);
  localparam int unsigned AW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] addr_p, addr_q;
  logic [CW-1:0] cnt_a, cnt_b;

  cpsat_ctrl #(.MAX_VERTICES(MAX_VERTICES), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_op_i   (in_i.operation),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cnt_a_i   (cnt_a),
    .cnt_b_i   (cnt_b),
    .cmd_o     (cmd),
    .addr_p_o  (addr_p),
    .addr_q_o  (addr_q)
  );

  cpsat_dp #(.MAX_VERTICES(MAX_VERTICES), .AW(AW), .CW(CW)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .addr_p_i          (addr_p),
    .addr_q_i          (addr_q),
    .coord_x_i         (in_i.coord_x),
    .coord_y_i         (in_i.coord_y),
    .dir_x_i           (in_i.dir_x),
    .dir_y_i           (in_i.dir_y),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .overlapping_o     (out_o.overlapping),
    .contact_found_o   (out_o.contact_found),
    .contact_distance_o(out_o.contact_distance),
    .normal_x_o        (out_o.normal_x),
    .normal_y_o        (out_o.normal_y),
    .sts_o             (sts),
    .cnt_a_o           (cnt_a),
    .cnt_b_o           (cnt_b)
  );
endmodule
`default_nettype wire

@@ design/cpsat_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpsat_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ design/cpsat_dp.sv @@
// Datapath of the contact block: vertex stores, shared multiplier,
// square root and divider steps, gap tracking and the result register.
// Depends on cpsat_pkg and cpsat_ram.
`default_nettype none
module cpsat_dp
  import cpsat_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 8,
  parameter int unsigned AW = $clog2(MAX_VERTICES),
  parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dp_cmd_t                    cmd_i,
  input  wire logic [AW-1:0]              addr_p_i,
  input  wire logic [AW-1:0]              addr_q_i,
  input  wire logic signed [COORD_W-1:0]  coord_x_i,
  input  wire logic signed [COORD_W-1:0]  coord_y_i,
  input  wire logic signed [COORD_W-1:0]  dir_x_i,
  input  wire logic signed [COORD_W-1:0]  dir_y_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic                            overlapping_o,
  output logic                            contact_found_o,
  output logic signed [DIST_W-1:0]        contact_distance_o,
  output logic signed [NORM_W-1:0]        normal_x_o,
  output logic signed [NORM_W-1:0]        normal_y_o,
  output dp_sts_t                         sts_o,
  output logic [CW-1:0]                   cnt_a_o,
  output logic [CW-1:0]                   cnt_b_o
);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic          any_q, sep_q, out_valid_q;

  logic signed [COORD_W-1:0] dirx_q, diry_q, p1x_q, p1y_q, qx_q, qy_q;
  logic signed [DIFF_W-1:0]  dx_q, dy_q;
  logic signed [PROD_W-1:0]  prod_q, acc_q;
  logic [LEN_W-1:0]          len2_q, v_q, res_q, bit_q;
  logic [SHIFT_W-1:0]        k_q;
  logic [REM_W-1:0]          rem_q, dsh_q;
  logic [QUO_W-1:0]          quo_q;
  logic signed [NORM_W-1:0]  nx_q, ny_q, bnx_q, bny_q;
  logic signed [PROJ_W-1:0]  pd_q, mn_q, gap_q, best_q;
  logic                      ovl_q, fnd_q;
  logic signed [DIST_W-1:0]  dist_q;
  logic signed [NORM_W-1:0]  onx_q, ony_q;

  logic                      we_a, we_b, re_a, re_b;
  logic [AW-1:0]             raddr_a, raddr_b;
  logic [VERT_W-1:0]         rd_a, rd_b, rd_p, rd_q;
  logic signed [COORD_W-1:0] rpx, rpy;
  logic signed [DIFF_W-1:0]  dx_w, dy_w, mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod_w;
  logic signed [PROJ_W-1:0]  sum_w;
  logic [LEN_W-1:0]          sq_t;
  logic                      sq_ge, div_ge;
  logic [DIFF_W-1:0]         mag_w;
  logic [LEN_W-1:0]          shl_w;
  logic [REM_W-1:0]          num_w;
  logic signed [NORM_W-1:0]  qs_w;
  logic                      reads_p, reads_q;
  logic                      found_w;
  logic signed [PROJ_W-1:0]  negb_w, qd_w;
  logic signed [DIST_W-1:0]  dist_w;

  assign we_a    = (cmd_i.op == DP_LOAD_A) && (cnt_a_q < MAX_CNT);
  assign we_b    = (cmd_i.op == DP_LOAD_B) && (cnt_b_q < MAX_CNT);
  assign reads_p = (cmd_i.op == DP_READ_P) || (cmd_i.op == DP_LATCH_P1);
  assign reads_q = (cmd_i.op == DP_READ_Q);
  assign re_a    = cmd_i.pass_b ? reads_q : reads_p;
  assign re_b    = cmd_i.pass_b ? reads_p : reads_q;
  assign raddr_a = cmd_i.pass_b ? addr_q_i : addr_p_i;
  assign raddr_b = cmd_i.pass_b ? addr_p_i : addr_q_i;
  assign rd_p    = cmd_i.pass_b ? rd_b : rd_a;
  assign rd_q    = cmd_i.pass_b ? rd_a : rd_b;

  cpsat_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (we_a),
    .waddr_i(cnt_a_q[AW-1:0]),
    .wdata_i({coord_x_i, coord_y_i}),
    .re_i   (re_a),
    .raddr_i(raddr_a),
    .rdata_o(rd_a)
  );

  cpsat_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (we_b),
    .waddr_i(cnt_b_q[AW-1:0]),
    .wdata_i({coord_x_i, coord_y_i}),
    .re_i   (re_b),
    .raddr_i(raddr_b),
    .rdata_o(rd_b)
  );

  assign rpx  = rd_p[VERT_W-1:COORD_W];
  assign rpy  = rd_p[COORD_W-1:0];
  assign dx_w = DIFF_W'(rpx) - DIFF_W'(p1x_q);
  assign dy_w = DIFF_W'(rpy) - DIFF_W'(p1y_q);

  always_comb begin
    mul_a = DIFF_W'(nx_q);
    mul_b = DIFF_W'(qx_q);
    case (cmd_i.op)
      DP_SQX:  begin mul_a = dx_q; mul_b = dx_q; end
      DP_SQY:  begin mul_a = dy_q; mul_b = dy_q; end
      DP_PD1:  begin mul_a = DIFF_W'(nx_q); mul_b = DIFF_W'(p1x_q); end
      DP_PD2:  begin mul_a = DIFF_W'(ny_q); mul_b = DIFF_W'(p1y_q); end
      DP_QM2:  begin mul_a = DIFF_W'(ny_q); mul_b = DIFF_W'(qy_q); end
      DP_DIR1: begin mul_a = DIFF_W'(nx_q); mul_b = DIFF_W'(dirx_q); end
      DP_DIR2: begin mul_a = DIFF_W'(ny_q); mul_b = DIFF_W'(diry_q); end
      default: begin mul_a = DIFF_W'(nx_q); mul_b = DIFF_W'(qx_q); end
    endcase
  end

  assign prod_w = mul_a * mul_b;
  assign sum_w  = PROJ_W'(acc_q) + PROJ_W'(prod_q);

  assign sq_t   = res_q + bit_q;
  assign sq_ge  = v_q >= sq_t;
  assign div_ge = rem_q >= dsh_q;

  always_comb begin
    if (cmd_i.op == DP_DIVY_INIT) begin
      mag_w = dx_q[DIFF_W-1] ? DIFF_W'(-dx_q) : DIFF_W'(dx_q);
    end else begin
      mag_w = dy_q[DIFF_W-1] ? DIFF_W'(-dy_q) : DIFF_W'(dy_q);
    end
  end

  assign shl_w = LEN_W'(mag_w) << k_q;
  assign num_w = REM_W'({shl_w[32:0], 14'b0}) + REM_W'(res_q[31:1]);
  assign qs_w  = NORM_W'(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      any_q       <= 1'b0;
      sep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (we_a) begin
        cnt_a_q <= cnt_a_q + CW'(1);
      end
      if (we_b) begin
        cnt_b_q <= cnt_b_q + CW'(1);
      end
      if (cmd_i.op == DP_CLEAR) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end
      if (cmd_i.op == DP_START) begin
        any_q <= 1'b0;
        sep_q <= 1'b0;
      end
      if ((cmd_i.op == DP_DIR3) && (sum_w != '0)) begin
        any_q <= 1'b1;
      end
      if (cmd_i.op == DP_SEP) begin
        sep_q <= 1'b1;
      end
      if (cmd_i.op == DP_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_START: begin
        dirx_q <= dir_x_i;
        diry_q <= dir_y_i;
      end
      DP_LATCH_P1: begin
        p1x_q <= rpx;
        p1y_q <= rpy;
      end
      DP_DIFF: begin
        dx_q <= dx_w;
        dy_q <= dy_w;
      end
      DP_SQX, DP_PD1, DP_QM1, DP_DIR1: begin
        prod_q <= prod_w;
      end
      DP_SQY: begin
        prod_q <= prod_w;
        len2_q <= LEN_W'($unsigned(prod_q));
      end
      DP_PD2, DP_QM2, DP_DIR2: begin
        prod_q <= prod_w;
        acc_q  <= prod_q;
      end
      DP_LEN: begin
        len2_q <= len2_q + LEN_W'($unsigned(prod_q));
        k_q    <= '0;
      end
      DP_NORM: begin
        if (|len2_q[LEN_W-1:LEN_W-4]) begin
          v_q   <= len2_q;
          res_q <= '0;
          bit_q <= LEN_W'(1) << (LEN_W - 2);
        end else begin
          len2_q <= len2_q << 2;
          k_q    <= k_q + SHIFT_W'(1);
        end
      end
      DP_SQRT: begin
        if (sq_ge) begin
          v_q   <= v_q - sq_t;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      DP_DIVX_INIT: begin
        rem_q <= num_w;
        dsh_q <= {2'b0, res_q[31:0], 14'b0};
        quo_q <= '0;
      end
      DP_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      DP_DIVY_INIT: begin
        nx_q  <= dy_q[DIFF_W-1] ? -qs_w : qs_w;
        rem_q <= num_w;
        dsh_q <= {2'b0, res_q[31:0], 14'b0};
        quo_q <= '0;
      end
      DP_DIV_END: begin
        ny_q <= (!dx_q[DIFF_W-1] && (dx_q != '0)) ? -qs_w : qs_w;
      end
      DP_PD3: begin
        pd_q <= sum_w;
      end
      DP_LATCH_Q: begin
        qx_q <= rd_q[VERT_W-1:COORD_W];
        qy_q <= rd_q[COORD_W-1:0];
      end
      DP_QM3: begin
        if (cmd_i.first || (sum_w < mn_q)) begin
          mn_q <= sum_w;
        end
      end
      DP_GAP: begin
        gap_q <= mn_q - pd_q;
      end
      DP_DIR3: begin
        if ((sum_w != '0) && (!any_q || (gap_q > best_q))) begin
          best_q <= gap_q;
          bnx_q  <= cmd_i.pass_b ? -nx_q : nx_q;
          bny_q  <= cmd_i.pass_b ? -ny_q : ny_q;
        end
      end
      DP_RESULT: begin
        ovl_q  <= !sep_q;
        fnd_q  <= found_w;
        dist_q <= dist_w;
        onx_q  <= found_w ? bnx_q : '0;
        ony_q  <= found_w ? bny_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign found_w = any_q && !sep_q;
  assign negb_w  = -best_q;
  assign qd_w    = (negb_w + PROJ_W'(16383)) >>> 14;

  always_comb begin
    dist_w = {1'b1, {(DIST_W-1){1'b0}}};
    if (found_w && (qd_w <= (PROJ_W'(1) <<< (DIST_W - 1)))) begin
      dist_w = -DIST_W'(qd_w);
    end
  end

  assign sts_o.len_zero   = (len2_q == '0);
  assign sts_o.norm_done  = |len2_q[LEN_W-1:LEN_W-4];
  assign sts_o.gap_nonneg = !gap_q[PROJ_W-1];
  assign sts_o.res_busy   = out_valid_q && !out_ready_i;

  assign cnt_a_o            = cnt_a_q;
  assign cnt_b_o            = cnt_b_q;
  assign out_valid_o        = out_valid_q;
  assign overlapping_o      = ovl_q;
  assign contact_found_o    = fnd_q;
  assign contact_distance_o = dist_q;
  assign normal_x_o         = onx_q;
  assign normal_y_o         = ony_q;
endmodule
`default_nettype wire

@@ design/cpsat_ctrl.sv @@
// Controller of the contact block: walks edges and vertices and issues
// one datapath command per cycle. Depends on cpsat_pkg.
`default_nettype none
module cpsat_ctrl
  import cpsat_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 8,
  parameter int unsigned AW = $clog2(MAX_VERTICES),
  parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_op_i,
  output logic               in_ready_o,
  input  wire dp_sts_t       sts_i,
  input  wire logic [CW-1:0] cnt_a_i,
  input  wire logic [CW-1:0] cnt_b_i,
  output dp_cmd_t            cmd_o,
  output logic [AW-1:0]      addr_p_o,
  output logic [AW-1:0]      addr_q_o
);
  typedef enum logic [5:0] {
    S_IDLE, S_TEST, S_RDP, S_P1, S_DIFF, S_SQX, S_SQY, S_LEN, S_CHK, S_NORM,
    S_SQRT, S_DIVX_INIT, S_DIVX, S_DIVY_INIT, S_DIVY, S_DIVEND, S_PD1, S_PD2,
    S_PD3, S_RDQ, S_LQ, S_QM1, S_QM2, S_QM3, S_GAP, S_GCHK, S_DIR1, S_DIR2,
    S_DIR3, S_NEXT, S_SEP, S_DONE
  } state_e;

  localparam logic [SHIFT_W-1:0] SQRT_LAST = SHIFT_W'(31);
  localparam logic [SHIFT_W-1:0] DIV_LAST  = SHIFT_W'(QUO_W - 1);

  state_e             state_q, state_d;
  logic [AW-1:0]      i_q, i_d, j_q, j_d;
  logic [SHIFT_W-1:0] iter_q, iter_d;
  logic               pass_q, pass_d;
  logic [CW-1:0]      pn, qn, i_inc, j_inc;
  logic [AW-1:0]      nxt;

  assign pn    = pass_q ? cnt_b_i : cnt_a_i;
  assign qn    = pass_q ? cnt_a_i : cnt_b_i;
  assign i_inc = CW'(i_q) + CW'(1);
  assign j_inc = CW'(j_q) + CW'(1);
  assign nxt   = (i_inc == pn) ? '0 : i_q + AW'(1);

  assign in_ready_o = (state_q == S_IDLE);
  assign addr_p_o   = (state_q == S_P1) ? nxt : i_q;
  assign addr_q_o   = j_q;

  always_comb begin
    state_d      = state_q;
    i_d          = i_q;
    j_d          = j_q;
    iter_d       = iter_q;
    pass_d       = pass_q;
    cmd_o.op     = DP_NOP;
    cmd_o.pass_b = pass_q;
    cmd_o.first  = (j_q == '0);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_op_i)
            OP_ADD_A: cmd_o.op = DP_LOAD_A;
            OP_ADD_B: cmd_o.op = DP_LOAD_B;
            OP_CLEAR: cmd_o.op = DP_CLEAR;
            OP_TEST: begin
              cmd_o.op = DP_START;
              state_d  = S_TEST;
            end
            default: cmd_o.op = DP_NOP;
          endcase
        end
      end
      S_TEST: begin
        pass_d = 1'b0;
        i_d    = '0;
        if ((cnt_a_i == '0) || (cnt_b_i == '0)) begin
          state_d = S_SEP;
        end else begin
          state_d = S_RDP;
        end
      end
      S_RDP: begin
        cmd_o.op = DP_READ_P;
        state_d  = S_P1;
      end
      S_P1: begin
        cmd_o.op = DP_LATCH_P1;
        state_d  = S_DIFF;
      end
      S_DIFF: begin
        cmd_o.op = DP_DIFF;
        state_d  = S_SQX;
      end
      S_SQX: begin
        cmd_o.op = DP_SQX;
        state_d  = S_SQY;
      end
      S_SQY: begin
        cmd_o.op = DP_SQY;
        state_d  = S_LEN;
      end
      S_LEN: begin
        cmd_o.op = DP_LEN;
        state_d  = S_CHK;
      end
      S_CHK: begin
        state_d = sts_i.len_zero ? S_NEXT : S_NORM;
      end
      S_NORM: begin
        cmd_o.op = DP_NORM;
        iter_d   = '0;
        if (sts_i.norm_done) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.op = DP_SQRT;
        iter_d   = iter_q + SHIFT_W'(1);
        if (iter_q == SQRT_LAST) begin
          state_d = S_DIVX_INIT;
        end
      end
      S_DIVX_INIT: begin
        cmd_o.op = DP_DIVX_INIT;
        iter_d   = '0;
        state_d  = S_DIVX;
      end
      S_DIVX: begin
        cmd_o.op = DP_DIV;
        iter_d   = iter_q + SHIFT_W'(1);
        if (iter_q == DIV_LAST) begin
          state_d = S_DIVY_INIT;
        end
      end
      S_DIVY_INIT: begin
        cmd_o.op = DP_DIVY_INIT;
        iter_d   = '0;
        state_d  = S_DIVY;
      end
      S_DIVY: begin
        cmd_o.op = DP_DIV;
        iter_d   = iter_q + SHIFT_W'(1);
        if (iter_q == DIV_LAST) begin
          state_d = S_DIVEND;
        end
      end
      S_DIVEND: begin
        cmd_o.op = DP_DIV_END;
        state_d  = S_PD1;
      end
      S_PD1: begin
        cmd_o.op = DP_PD1;
        state_d  = S_PD2;
      end
      S_PD2: begin
        cmd_o.op = DP_PD2;
        state_d  = S_PD3;
      end
      S_PD3: begin
        cmd_o.op = DP_PD3;
        j_d      = '0;
        state_d  = S_RDQ;
      end
      S_RDQ: begin
        cmd_o.op = DP_READ_Q;
        state_d  = S_LQ;
      end
      S_LQ: begin
        cmd_o.op = DP_LATCH_Q;
        state_d  = S_QM1;
      end
      S_QM1: begin
        cmd_o.op = DP_QM1;
        state_d  = S_QM2;
      end
      S_QM2: begin
        cmd_o.op = DP_QM2;
        state_d  = S_QM3;
      end
      S_QM3: begin
        cmd_o.op = DP_QM3;
        if (j_inc < qn) begin
          j_d     = j_q + AW'(1);
          state_d = S_RDQ;
        end else begin
          state_d = S_GAP;
        end
      end
      S_GAP: begin
        cmd_o.op = DP_GAP;
        state_d  = S_GCHK;
      end
      S_GCHK: begin
        state_d = sts_i.gap_nonneg ? S_SEP : S_DIR1;
      end
      S_DIR1: begin
        cmd_o.op = DP_DIR1;
        state_d  = S_DIR2;
      end
      S_DIR2: begin
        cmd_o.op = DP_DIR2;
        state_d  = S_DIR3;
      end
      S_DIR3: begin
        cmd_o.op = DP_DIR3;
        state_d  = S_NEXT;
      end
      S_NEXT: begin
        if (i_inc < pn) begin
          i_d     = i_q + AW'(1);
          state_d = S_RDP;
        end else if (!pass_q) begin
          pass_d  = 1'b1;
          i_d     = '0;
          state_d = S_RDP;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SEP: begin
        cmd_o.op = DP_SEP;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!sts_i.res_busy) begin
          cmd_o.op = DP_RESULT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      iter_q  <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      iter_q  <= iter_d;
      pass_q  <= pass_d;
    end
  end
endmodule
`default_nettype wire

@@ design/cpsat_checker.sv @@
// Port-level checks for the contact block, bound to its top level.
// Depends on cpsat_pkg and convex_polygon_sat_contact.
`default_nettype none
module cpsat_checker
  import cpsat_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic [1:0]                in_operation,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      overlapping,
  input wire logic                      contact_found,
  input wire logic signed [DIST_W-1:0]  contact_distance,
  input wire logic signed [NORM_W-1:0]  normal_x,
  input wire logic signed [NORM_W-1:0]  normal_y
);
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && (in_operation == OP_TEST) |=> !in_ready)
    else $error("input taken while a test runs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !contact_found |->
      (contact_distance == DIST_MIN) && (normal_x == '0) && (normal_y == '0))
    else $error("missing contact carries a distance or normal");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && contact_found |-> overlapping && contact_distance[DIST_W-1])
    else $error("contact without overlap or with nonnegative distance");
endmodule

bind convex_polygon_sat_contact cpsat_checker u_cpsat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .in_operation    (in_i.operation),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .overlapping     (out_o.overlapping),
  .contact_found   (out_o.contact_found),
  .contact_distance(out_o.contact_distance),
  .normal_x        (out_o.normal_x),
  .normal_y        (out_o.normal_y)
);
`default_nettype wire
